// ===== design/modexp_pkg.sv =====
// Shared types for the modular exponentiation block.
// No dependencies; imported by modexp_mulcell and modular_exponentiation.
package modexp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ROUND,
    ST_DONE
  } modexp_state_t;

  // Status that a multiplier cell hands back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } cell_status_t;

endpackage

// ===== design/modexp_mulcell.sv =====
// Shift-add modular multiplier cell: one multiplier bit per cycle.
// Depends on modexp_pkg (cell_status_t).
module modexp_mulcell #(
  parameter int WIDTH = 63
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [WIDTH-1:0]          mcand,   // must be below modulus
  input  logic [WIDTH-1:0]          mplier,  // any value
  input  logic [WIDTH-1:0]          modulus,
  output logic [WIDTH-1:0]          product,
  output modexp_pkg::cell_status_t  status
);
  import modexp_pkg::*;

  localparam int CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc, acc_next;
  logic [WIDTH-1:0] x, m, ysh;
  logic [CntW-1:0]  cnt;
  logic             busy, done;
  logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;

  // Double, reduce, conditionally add the multiplicand, reduce.
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = ysh[WIDTH-1] ? dbl_red + {1'b0, x} : dbl_red;
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
    acc_next = sum_red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      x   <= mcand;
      m   <= modulus;
      ysh <= mplier;
    end else if (busy) begin
      acc <= acc_next;
      ysh <= {ysh[WIDTH-2:0], 1'b0};
    end
  end

  assign product     = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== design/modular_exponentiation.sv =====
// One item at a time: a zero exponent or zero modulus skips the multiplier cells and
// goes straight to the output; otherwise the two multiplier cells set the pace.
// Reset (rst, synchronous) empties the sequencer and the output register.
// Depends on modexp_pkg and modexp_mulcell.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 63
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] base_value,
  input  logic [OPERAND_WIDTH-1:0] exponent_value,
  input  logic [OPERAND_WIDTH-1:0] modulus_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] power_result
);
  import modexp_pkg::*;

  localparam int W = OPERAND_WIDTH;

  modexp_state_t state, state_next;

  // Item working registers: remaining exponent, modulus, reduced base, result.
  logic [W-1:0] expo, modr, base_r, res;
  logic [W-1:0] mul_prod, sq_prod;
  cell_status_t mul_st, sq_st;

  logic         start;
  logic [W-1:0] mul_x, mul_y;
  logic         in_take;
  logic         out_load;

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: reduce the base once, then one square/multiply round per
  // exponent bit, both cells running side by side.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    start      = 1'b0;
    mul_x      = base_r;
    mul_y      = res;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (exponent_value == '0 || modulus_value == '0) begin
            state_next = ST_DONE;
          end else begin
            // base * 1 mod m: the cell reduces an unreduced base
            start      = 1'b1;
            mul_x      = (modulus_value == W'(1)) ? '0 : W'(1);
            mul_y      = base_value;
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_st.done) begin
          start      = 1'b1;
          mul_x      = mul_prod;
          mul_y      = res;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (sq_st.done) begin
          if ((expo >> 1) == '0) begin
            state_next = ST_DONE;
          end else begin
            start = 1'b1;
            mul_x = sq_prod;
            mul_y = expo[0] ? mul_prod : res;
            state_next = ST_ROUND;
          end
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      expo <= exponent_value;
      modr <= modulus_value;
      res  <= (exponent_value != '0 && modulus_value == '0) ? '0 : W'(1);
    end else if (state == ST_REDUCE && mul_st.done) begin
      base_r <= mul_prod;
    end else if (state == ST_ROUND && sq_st.done) begin
      if (expo[0]) begin
        res <= mul_prod;
      end
      base_r <= sq_prod;
      expo   <= expo >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      power_result <= res;
    end
  end

  // Multiply cell: result * base (also base reduction). Square cell: base^2.
  modexp_mulcell #(.WIDTH(W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mcand   (mul_x),
    .mplier  (mul_y),
    .modulus ((state == ST_IDLE) ? modulus_value : modr),
    .product (mul_prod),
    .status  (mul_st)
  );

  modexp_mulcell #(.WIDTH(W)) u_sq (
    .clk     (clk),
    .rst     (rst),
    .start   (start && state != ST_IDLE),
    .mcand   (mul_x),
    .mplier  (mul_x),
    .modulus (modr),
    .product (sq_prod),
    .status  (sq_st)
  );

  a_cells_lockstep: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> sq_st.done == mul_st.done)
    else $error("square and multiply cells out of step");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |-> state == ST_IDLE)
    else $error("item taken while busy");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == ST_IDLE)
    else $error("result load lost");

endmodule
